FILE: sv/lkdw_pkg.sv
// Shared constants, types and the byte folding table of the k-distinct window unit.
package lkdw_pkg;

   localparam int MAX_LEN     = 4096;
   localparam int ALPHABET    = 256;
   localparam int CHAR_W      = 8;
   localparam int CHAR_VALUES = 1 << CHAR_W;
   localparam int TARGET_W    = 9;
   localparam int LEN_W       = 13;
   localparam int SYM_W       = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int POS_W       = $clog2(MAX_LEN + 1);
   localparam int ADDR_W      = $clog2(MAX_LEN);
   localparam int CNT_W       = POS_W;
   localparam int DIST_W      = $clog2(ALPHABET + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1);

   typedef logic [SYM_W-1:0] fold_lut_type [CHAR_VALUES];

   // One classified byte on its way from the front end to the back end.
   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             is_last;
      logic             keep;
   } lkdw_item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ADD,
      BK_EV_RD,
      BK_EV_CNT,
      BK_OUT
   } lkdw_back_state_type;

   function automatic fold_lut_type build_fold_lut();
      fold_lut_type lut;
      for (int i = 0; i < CHAR_VALUES; i++) begin
         lut[i] = SYM_W'(i % ALPHABET);
      end
      return lut;
   endfunction

   localparam fold_lut_type FOLD_LUT = build_fold_lut();

endpackage

FILE: sv/lkdw_channels.sv
// Valid/ready channel interfaces for the byte input and the result output.
interface lkdw_req_if;
   logic                         valid;
   logic                         ready;
   logic [lkdw_pkg::CHAR_W-1:0]  char_in;
   logic                         is_last;

   modport source (output valid, output char_in, output is_last, input ready);
   modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface lkdw_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lkdw_pkg::LEN_W-1:0]   best_length;
   logic                         found;
   logic                         too_long;

   modport source (output valid, output best_length, output found, output too_long,
                   input ready);
   modport sink   (input valid, input best_length, input found, input too_long,
                   output ready);
endinterface

FILE: sv/lkdw_front.sv
// Front end: accepts bytes, folds them and marks those past the length limit.
module lkdw_front (
   input  logic                    clock,
   input  logic                    reset,
   lkdw_req_if.sink                req_if,
   output logic                    push_valid,
   output lkdw_pkg::lkdw_item_type push_item,
   input  logic                    push_ready
);
   import lkdw_pkg::*;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             keep;

   assign keep          = (pos_ff < POS_W'(MAX_LEN));
   assign req_if.ready  = push_ready;
   assign push_valid    = req_if.valid;
   assign push_item.sym = FOLD_LUT[req_if.char_in];
   assign push_item.is_last = req_if.is_last;
   assign push_item.keep    = keep;

   always_comb begin
      pos_in = pos_ff;
      if (req_if.valid && push_ready) begin
         if (req_if.is_last) begin
            pos_in = '0;
         end else if (keep) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: sv/lkdw_queue.sv
// Small FIFO of classified bytes between the front end and the back end.
module lkdw_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  lkdw_pkg::lkdw_item_type push_item,
   output logic                    push_ready,
   output logic                    pop_valid,
   output lkdw_pkg::lkdw_item_type pop_item,
   input  logic                    pop_ready
);
   import lkdw_pkg::*;

   lkdw_item_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   fill_ff;
   logic                push_go;
   logic                pop_go;

   assign push_ready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_go    = push_valid && push_ready;
   assign pop_go     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push_go) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push_go) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop_go) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push_go && !pop_go) begin
            fill_ff <= fill_ff + QCNT_W'(1);
         end else if (pop_go && !push_go) begin
            fill_ff <= fill_ff - QCNT_W'(1);
         end
      end
   end

endmodule

FILE: sv/lkdw_back.sv
// Back end: count table, window memory, eviction sequencer and result register.
module lkdw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lkdw_pkg::TARGET_W-1:0] distinct_target,
   input  logic                          q_valid,
   input  lkdw_pkg::lkdw_item_type       q_item,
   output logic                          q_ready,
   lkdw_rsp_if.source                    rsp_if
);
   import lkdw_pkg::*;

   // Count table and window memory, both with registered read data.
   logic [CNT_W-1:0]   cnt_mem [ALPHABET];
   logic [SYM_W-1:0]   fifo_mem [MAX_LEN];
   logic               cnt_valid_ff [ALPHABET];

   logic               cnt_we;
   logic [SYM_W-1:0]   cnt_wa;
   logic [CNT_W-1:0]   cnt_wd;
   logic [SYM_W-1:0]   cnt_ra;
   logic [CNT_W-1:0]   cnt_rd_ff;
   logic               cnt_rd_vld_ff;
   logic [CNT_W-1:0]   cnt_eff;
   logic               clear_valid;

   logic               fifo_we;
   logic [ADDR_W-1:0]  fifo_wa;
   logic [SYM_W-1:0]   fifo_wd;
   logic [ADDR_W-1:0]  fifo_ra;
   logic [SYM_W-1:0]   fifo_rd_ff;

   lkdw_back_state_type state_ff, state_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic [POS_W-1:0]   end_ff, end_in;
   logic [DIST_W-1:0]  distinct_ff, distinct_in;
   logic [POS_W-1:0]   best_ff, best_in;
   logic               seen_ff, seen_in;
   logic               ovf_ff, ovf_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic               last_ff, last_in;
   logic [SYM_W-1:0]   old_ff, old_in;

   logic               rsp_valid_ff;
   logic [LEN_W-1:0]   rsp_best_ff;
   logic               rsp_found_ff;
   logic               rsp_too_long_ff;
   logic               out_load;

   logic [DIST_W-1:0]  d_add;
   logic [DIST_W-1:0]  d_ev;
   logic [POS_W-1:0]   start_inc;
   logic               settle;
   logic [DIST_W-1:0]  settle_d;
   logic [POS_W-1:0]   settle_start;
   logic [POS_W-1:0]   settle_len;

   assign cnt_eff   = cnt_rd_vld_ff ? cnt_rd_ff : '0;
   assign d_add     = distinct_ff + DIST_W'(cnt_eff == '0);
   assign d_ev      = (cnt_eff == CNT_W'(1)) ? distinct_ff - DIST_W'(1) : distinct_ff;
   assign start_inc = start_ff + POS_W'(1);
   assign settle_len = end_ff - settle_start;

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      distinct_in  = distinct_ff;
      best_in      = best_ff;
      seen_in      = seen_ff;
      ovf_in       = ovf_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      old_in       = old_ff;
      q_ready      = 1'b0;
      cnt_we       = 1'b0;
      cnt_wa       = sym_ff;
      cnt_wd       = cnt_eff;
      cnt_ra       = sym_ff;
      fifo_we      = 1'b0;
      fifo_wa      = end_ff[ADDR_W-1:0];
      fifo_wd      = q_item.sym;
      fifo_ra      = start_ff[ADDR_W-1:0];
      out_load     = 1'b0;
      clear_valid  = 1'b0;
      settle       = 1'b0;
      settle_d     = distinct_ff;
      settle_start = start_ff;

      case (state_ff)
         BK_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               sym_in  = q_item.sym;
               last_in = q_item.is_last;
               if (q_item.keep) begin
                  fifo_we  = 1'b1;
                  cnt_ra   = q_item.sym;
                  end_in   = end_ff + POS_W'(1);
                  state_in = BK_ADD;
               end else begin
                  ovf_in   = 1'b1;
                  state_in = q_item.is_last ? BK_OUT : BK_IDLE;
               end
            end
         end
         BK_ADD: begin
            cnt_we      = 1'b1;
            cnt_wa      = sym_ff;
            cnt_wd      = cnt_eff + CNT_W'(1);
            distinct_in = d_add;
            if (TARGET_W'(d_add) > distinct_target) begin
               fifo_ra  = start_ff[ADDR_W-1:0];
               state_in = BK_EV_RD;
            end else begin
               settle   = 1'b1;
               settle_d = d_add;
            end
         end
         BK_EV_RD: begin
            cnt_ra   = fifo_rd_ff;
            old_in   = fifo_rd_ff;
            state_in = BK_EV_CNT;
         end
         BK_EV_CNT: begin
            if (cnt_eff != '0) begin
               cnt_we = 1'b1;
               cnt_wa = old_ff;
               cnt_wd = cnt_eff - CNT_W'(1);
            end
            distinct_in = d_ev;
            start_in    = start_inc;
            if ((TARGET_W'(d_ev) > distinct_target) && (start_inc < end_ff)) begin
               fifo_ra  = start_inc[ADDR_W-1:0];
               state_in = BK_EV_RD;
            end else begin
               settle       = 1'b1;
               settle_d     = d_ev;
               settle_start = start_inc;
            end
         end
         BK_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               out_load    = 1'b1;
               clear_valid = 1'b1;
               start_in    = '0;
               end_in      = '0;
               distinct_in = '0;
               best_in     = '0;
               seen_in     = 1'b0;
               ovf_in      = 1'b0;
               state_in    = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // The byte is fully absorbed: score the window and move on.
      if (settle) begin
         if (TARGET_W'(settle_d) == distinct_target) begin
            seen_in = 1'b1;
            if (settle_len > best_ff) begin
               best_in = settle_len;
            end
         end
         state_in = last_ff ? BK_OUT : BK_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff     <= cnt_mem[cnt_ra];
      cnt_rd_vld_ff <= cnt_valid_ff[cnt_ra];
   end

   always_ff @(posedge clock) begin
      if (reset || clear_valid) begin
         for (int i = 0; i < ALPHABET; i++) begin
            cnt_valid_ff[i] <= 1'b0;
         end
      end else if (cnt_we) begin
         cnt_valid_ff[cnt_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[fifo_wa] <= fifo_wd;
      end
      fifo_rd_ff <= fifo_mem[fifo_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         start_ff    <= '0;
         end_ff      <= '0;
         distinct_ff <= '0;
         best_ff     <= '0;
         seen_ff     <= 1'b0;
         ovf_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         start_ff    <= start_in;
         end_ff      <= end_in;
         distinct_ff <= distinct_in;
         best_ff     <= best_in;
         seen_ff     <= seen_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      last_ff <= last_in;
      old_ff  <= old_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_best_ff     <= seen_ff ? LEN_W'(best_ff) : '0;
         rsp_found_ff    <= seen_ff;
         rsp_too_long_ff <= ovf_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.best_length = rsp_best_ff;
   assign rsp_if.found       = rsp_found_ff;
   assign rsp_if.too_long    = rsp_too_long_ff;

   a_start_le_end: assert property (@(posedge clock) disable iff (reset)
      start_ff <= end_ff)
      else $error("window start passed window end");

   a_distinct_bound: assert property (@(posedge clock) disable iff (reset)
      distinct_ff <= DIST_W'(ALPHABET))
      else $error("distinct count above alphabet size");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_best_ff == '0))
      else $error("not-found result carries a length");

   a_clear_after_out: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (end_ff == '0 && distinct_ff == '0 && rsp_valid_ff
                    && state_ff == BK_IDLE))
      else $error("string state not cleared after result");

endmodule

FILE: sv/longest_k_distinct_window_unit.sv
// Top level of the longest k-distinct window unit: front end, queue, back end, target register.
//
// The unit takes a string one byte per transfer on req_if and, on the byte marked
// is_last, returns one transfer on rsp_if with the length of the longest window that
// holds exactly distinct_target different byte values (found = 0 and length 0 if no
// window qualifies), plus too_long when the string ran past MAX_LEN bytes; bytes past
// that limit are dropped and only the first MAX_LEN are scored. The front end folds
// each byte into the alphabet and marks overlong bytes, a four-entry queue decouples
// it from the back end, and the back end runs a small sequencer over a per-symbol
// count table and a MAX_LEN-deep window memory, both single-port-write memories with
// registered reads. A byte that leaves the distinct count at or below the target passes
// through a count read and a count write; each byte evicted from the left of the window
// adds a read of the window memory and then an update of that symbol's count, and every
// byte is evicted at most once. A byte dropped past the length limit sets the overflow
// flag, and the result is handed over from a separate output state. The count table is
// cleared at the end of every string through per-entry valid bits, so no clearing pass
// is needed and the next string can start on the following cycle. The result register
// lets the back end keep working while a finished result waits to be taken. csr_wdata
// is written into distinct_target (reset value 1) whenever csr_we is high; change it
// only while the unit is idle.
module longest_k_distinct_window_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [lkdw_pkg::TARGET_W-1:0] csr_wdata,
   lkdw_req_if.sink                      req_if,
   lkdw_rsp_if.source                    rsp_if
);
   import lkdw_pkg::*;

   logic [TARGET_W-1:0] target_ff;
   logic                push_valid;
   lkdw_item_type       push_item;
   logic                push_ready;
   logic                q_valid;
   lkdw_item_type       q_item;
   logic                q_ready;

   // Target register: a plain write-only control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
      end else if (csr_we) begin
         target_ff <= csr_wdata;
      end
   end

   // Front end classifies each transfer and pushes it into the queue.
   lkdw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // The queue lets the input keep flowing while the back end is evicting.
   lkdw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop_ready  (q_ready)
   );

   // The back end owns all window state and the result register.
   lkdw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .distinct_target (target_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_ready         (q_ready),
      .rsp_if          (rsp_if)
   );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the longest k-distinct window unit.
module testbench;
   import lkdw_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 8;     // quiet time before a target change
   localparam int unsigned DRAIN_CYCLES  = 40;    // quiet time after the last result
   localparam int unsigned HOLD_CYCLES   = 500;   // long result-side hold-off
   localparam int unsigned IDLE_LIMIT    = 40000; // cycles without any transfer
   localparam int unsigned RANDOM_ITEMS  = 700;
   localparam int unsigned SCRIPT_ROWS   = 21;

   typedef struct packed {
      logic [LEN_W-1:0] best_length;
      logic             found;
      logic             too_long;
   } window_result_type;

   // One row sends copies bytes, starting at ch and stepping by step.
   // Only the final byte of a row carries the row's last flag.
   typedef struct {
      bit                  set_target;
      logic [TARGET_W-1:0] target;
      logic [CHAR_W-1:0]   ch;
      int unsigned         copies;
      int unsigned         step;
      bit                  last;
      bit                  typed;
      window_result_type   want;
   } script_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [TARGET_W-1:0] csr_wdata;

   lkdw_req_if req_ch ();
   lkdw_rsp_if rsp_ch ();

   longest_k_distinct_window_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Window predictor state, one copy of everything the unit keeps per string.
   logic [TARGET_W-1:0] target_k = TARGET_RESET;
   logic [CNT_W-1:0]    sym_count [ALPHABET];
   logic [DIST_W-1:0]   held_distinct = '0;
   logic [CHAR_W-1:0]   win_mem [MAX_LEN];
   logic [POS_W-1:0]    win_head = '0;
   logic [POS_W-1:0]    win_tail = '0;
   logic [POS_W-1:0]    best_len = '0;
   bit                  any_match = 1'b0;
   bit                  overrun = 1'b0;

   window_result_type pending_results [$];
   int unsigned       mismatches = 0;
   int unsigned       results_seen = 0;
   int unsigned       quiet_cycles = 0;
   int unsigned       recv_gap_max = 9;
   bit                hold_pending = 1'b0;

   // Directed strings. Expected results are typed in where they are obvious.
   script_row_type script [SCRIPT_ROWS] = '{
      // Reset target of one, a single byte.
      '{1'b0, 9'd0,   8'h41, 1,    0, 1'b1, 1'b1, '{13'd1,    1'b1, 1'b0}},
      '{1'b0, 9'd0,   8'h00, 2,    0, 1'b0, 1'b0, '0},
      '{1'b0, 9'd0,   8'hFF, 1,    0, 1'b1, 1'b0, '0},
      // Two distinct values, with an eviction at the end.
      '{1'b1, 9'd2,   8'h00, 1,    0, 1'b0, 1'b0, '0},
      '{1'b0, 9'd0,   8'hFF, 1,    0, 1'b0, 1'b0, '0},
      '{1'b0, 9'd0,   8'h00, 1,    0, 1'b0, 1'b0, '0},
      '{1'b0, 9'd0,   8'h7F, 1,    0, 1'b1, 1'b0, '0},
      // Target above the string length, then above the alphabet.
      '{1'b1, 9'd256, 8'h61, 1,    0, 1'b0, 1'b0, '0},
      '{1'b0, 9'd0,   8'h62, 1,    0, 1'b1, 1'b1, '{13'd0,    1'b0, 1'b0}},
      '{1'b1, 9'd511, 8'h80, 1,    0, 1'b1, 1'b1, '{13'd0,    1'b0, 1'b0}},
      // Target zero: the empty window qualifies.
      '{1'b1, 9'd0,   8'h71, 1,    0, 1'b0, 1'b0, '0},
      '{1'b0, 9'd0,   8'h72, 1,    0, 1'b1, 1'b1, '{13'd0,    1'b1, 1'b0}},
      // Fewer distinct values than the target.
      '{1'b1, 9'd3,   8'h55, 1,    0, 1'b0, 1'b0, '0},
      '{1'b0, 9'd0,   8'hAA, 1,    0, 1'b0, 1'b0, '0},
      '{1'b0, 9'd0,   8'h55, 1,    0, 1'b1, 1'b1, '{13'd0,    1'b0, 1'b0}},
      // Every byte value in one window, which then keeps growing.
      '{1'b1, 9'd256, 8'h00, 300,  1, 1'b1, 1'b1, '{13'd300,  1'b1, 1'b0}},
      // A full-length window of one value.
      '{1'b1, 9'd1,   8'h41, 4096, 0, 1'b1, 1'b1, '{13'd4096, 1'b1, 1'b0}},
      // Overlong strings: only the first MAX_LEN bytes count.
      '{1'b0, 9'd0,   8'h41, 4000, 0, 1'b0, 1'b0, '0},
      '{1'b0, 9'd0,   8'h42, 100,  0, 1'b1, 1'b1, '{13'd4000, 1'b1, 1'b1}},
      '{1'b1, 9'd2,   8'h01, 3000, 0, 1'b0, 1'b0, '0},
      '{1'b0, 9'd0,   8'hFE, 1200, 0, 1'b1, 1'b1, '{13'd4096, 1'b1, 1'b1}}
   };

   initial begin
      foreach (sym_count[s]) sym_count[s] = '0;
   end

   // Folds one byte into the window. Returns 1 with the string's result on a last byte.
   function automatic bit predict_byte(input logic [CHAR_W-1:0] ch, input logic last,
                                       output window_result_type res);
      logic [SYM_W-1:0] sym;
      logic [SYM_W-1:0] old;
      sym = SYM_W'(ch % ALPHABET);
      res = '0;
      if (win_tail >= POS_W'(MAX_LEN)) begin
         overrun = 1'b1;
      end else begin
         win_mem[win_tail[ADDR_W-1:0]] = ch;
         win_tail++;
         if (sym_count[sym] == '0) held_distinct++;
         sym_count[sym]++;
         // Too many distinct values: drop bytes from the left, oldest first.
         while (held_distinct > DIST_W'(target_k) && win_head < win_tail) begin
            old = SYM_W'(win_mem[win_head[ADDR_W-1:0]] % ALPHABET);
            if (sym_count[old] != '0) begin
               sym_count[old]--;
               if (sym_count[old] == '0) held_distinct--;
            end
            win_head++;
         end
         if (held_distinct == DIST_W'(target_k)) begin
            if (win_tail - win_head > best_len) best_len = win_tail - win_head;
            any_match = 1'b1;
         end
      end
      if (!last) return 1'b0;
      res.best_length = any_match ? LEN_W'(best_len) : '0;
      res.found       = any_match;
      res.too_long    = overrun;
      foreach (sym_count[s]) sym_count[s] = '0;
      held_distinct = '0;
      win_head      = '0;
      win_tail      = '0;
      best_len      = '0;
      any_match     = 1'b0;
      overrun       = 1'b0;
      return 1'b1;
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      mismatches++;
      $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
               results_seen, what, got, want);
   endtask

   // Offers one byte after a random gap and waits for its transfer.
   // Valid stays high afterwards so that a back-to-back byte needs no second write.
   task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic last,
                            input int unsigned gap_max, input bit typed,
                            input window_result_type want);
      int unsigned       gap;
      window_result_type predicted;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.char_in <= ch;
      req_ch.is_last <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (predict_byte(ch, last, predicted)) begin
         pending_results.push_back(typed ? want : predicted);
      end
   endtask

   // Waits until every string has returned its result, lets the unit settle,
   // then writes a new target.
   task automatic program_target(input logic [TARGET_W-1:0] value);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      target_k = value;
      csr_we <= 1'b0;
   endtask

   // Result side: random stalls, one long hold-off on request, field-wise checks.
   initial begin
      int unsigned       gap;
      window_result_type want;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = $urandom_range(0, recv_gap_max);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         results_seen++;
         if (pending_results.size() == 0) begin
            flag_mismatch("result with nothing expected, best_length",
                          rsp_ch.best_length, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.best_length !== want.best_length)
               flag_mismatch("best_length", rsp_ch.best_length, want.best_length);
            if (rsp_ch.found !== want.found)
               flag_mismatch("found", rsp_ch.found, want.found);
            if (rsp_ch.too_long !== want.too_long)
               flag_mismatch("too_long", rsp_ch.too_long, want.too_long);
         end
      end
   end

   // Ends the run when neither channel has moved a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic                is_end;
      logic [TARGET_W-1:0] next_target;
      logic [CHAR_W-1:0]   char_pool [6];
      logic [CHAR_W-1:0]   ch;
      int unsigned         pool_size;
      int unsigned         str_len;
      int unsigned         strings;
      int unsigned         send_gap_max;
      int unsigned         random_items;
      int unsigned         phase;

      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.char_in <= '0;
      req_ch.is_last <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed strings. Long rows run without gaps to keep the run short.
      foreach (script[r]) begin
         if (script[r].set_target) program_target(script[r].target);
         for (int unsigned n = 0; n < script[r].copies; n++) begin
            is_end = script[r].last && (n == script[r].copies - 1);
            send_byte(script[r].ch + CHAR_W'(n * script[r].step), is_end,
                      (script[r].copies > 1) ? 0 : 9, script[r].typed, script[r].want);
         end
      end

      // Random strings in phases, each phase with its own target and idling mode.
      // Most bytes come from a small pool so that the target is often reached.
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       next_target = '0;
            1:       next_target = TARGET_W'(ALPHABET);
            2:       next_target = '1;
            3:       next_target = TARGET_W'($urandom_range(0, 511));
            default: next_target = TARGET_W'($urandom_range(1, 5));
         endcase
         program_target(next_target);
         send_gap_max = $urandom_range(0, 1) ? 9 : 0;
         recv_gap_max = $urandom_range(0, 1) ? 9 : 0;
         strings = $urandom_range(4, 10);
         // In one phase the result side stops for a long time while bytes keep
         // coming, so the unit fills up and must stall its input.
         if (phase == 2) begin
            hold_pending = 1'b1;
            strings = 10;
         end
         repeat (strings) begin
            pool_size = $urandom_range(1, 6);
            foreach (char_pool[p]) char_pool[p] = CHAR_W'($urandom_range(0, 255));
            str_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 120)
                                                  : $urandom_range(1, 16);
            for (int unsigned k = 0; k < str_len; k++) begin
               if ($urandom_range(0, 7) == 0) ch = CHAR_W'($urandom_range(0, 255));
               else ch = char_pool[$urandom_range(0, pool_size - 1)];
               send_byte(ch, k == str_len - 1, send_gap_max, 1'b0, '0);
               random_items++;
            end
         end
         phase++;
      end

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         flag_mismatch("results never returned", pending_results.size(), 0);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: longest_k_distinct_window_unit.f
sv/lkdw_pkg.sv
sv/lkdw_channels.sv
sv/lkdw_front.sv
sv/lkdw_queue.sv
sv/lkdw_back.sv
sv/longest_k_distinct_window_unit.sv
sim/testbench.sv
